// ===== hdl/quadratic_table_interpolator_top_defines.svh =====
// Assertion macros shared by the checker of the quadratic table interpolator.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef QUADRATIC_TABLE_INTERPOLATOR_TOP_DEFINES_SVH
`define QUADRATIC_TABLE_INTERPOLATOR_TOP_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define QTI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define QTI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/qti_pkg.sv =====
// Shared types and constants of the quadratic table interpolator.
// Depends on nothing; used by the top level and its checker.
`default_nettype none

package qti_pkg;

    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_TABLE_START  = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_INVERSE_STEP = 1'd1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [31:0] TABLE_START_RESET  = 32'h0000_0000;
    localparam logic [31:0] INVERSE_STEP_RESET = 32'h0001_0000;
    localparam logic [15:0] CHI_HALF           = 16'h8000;
    localparam logic [16:0] CHI_ONE            = 17'h1_0000;

    typedef struct packed {
        logic               req_type;
        logic [9:0]         row_index;
        logic [3:0]         column;
        logic signed [31:0] entry_value;
        logic [31:0]        query_position;
    } t_req;

    typedef struct packed {
        logic signed [31:0] pot_value;
        logic signed [31:0] gradient;
    } t_res;

endpackage

`default_nettype wire

// ===== hdl/qti_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`default_nettype none

module qti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/quadratic_table_interpolator_top.sv =====
// Top level of the quadratic table interpolator: configuration, pipeline and table.
// Depends on qti_pkg and qti_ram.
// A query result passes through stage registers s1 to s7 and the result register to the result ports.
// Throughput: one item per cycle, loads and queries alike; three table copies give three reads.
// Reset presets the configuration, clears the per-column row records and the pipeline; busy is high
// only during reset. Table contents are undefined until loaded. Results cannot be stalled.
`default_nettype none

module quadratic_table_interpolator_top #(
    parameter int ROWS    = 1024,
    parameter int COLUMNS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire qti_pkg::t_req                i_req,
    output logic                              o_res_valid,
    output qti_pkg::t_res                     o_res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [qti_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int KW    = RW + 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS << CW;
    localparam int NCOL  = 1 << CW;
    localparam int NTAP  = 3;

    function automatic logic signed [31:0] sat_q(input logic signed [53:0] x);
        logic signed [31:0] y;
        if (x > 54'sh0_0000_7FFF_FFFF) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < -54'sh0_0000_8000_0000) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    // Configuration registers.
    logic [31:0] r_table_start;
    logic [31:0] r_inv_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_start <= qti_pkg::TABLE_START_RESET;
            r_inv_step    <= qti_pkg::INVERSE_STEP_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2:2])
                qti_pkg::REG_TABLE_START:  r_table_start <= pwdata;
                qti_pkg::REG_INVERSE_STEP: r_inv_step    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2:2])
            qti_pkg::REG_TABLE_START:  prdata = r_table_start;
            qti_pkg::REG_INVERSE_STEP: prdata = r_inv_step;
            default:                   prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign busy   = ~i_rst_n;

    // Accept stage.
    logic          w_accept;
    logic [CW+3:0] w_col_ext;
    logic [31:0]   w_row_ext;
    logic [31:0]   w_diff;

    assign w_accept  = start && !busy;
    assign w_col_ext = (CW+4)'(i_req.column);
    assign w_row_ext = 32'(i_req.row_index);
    assign w_diff    = (i_req.query_position >= r_table_start)
                       ? (i_req.query_position - r_table_start) : 32'd0;

    logic          r_s1_vld;
    logic          r_s1_load;
    logic          r_s1_col_ok;
    logic          r_s1_row_ok;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    logic [31:0]   r_s1_val;
    logic [31:0]   r_s1_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_accept;
        end
        r_s1_load   <= (i_req.req_type == qti_pkg::REQ_LOAD);
        r_s1_col_ok <= (w_col_ext < (CW+4)'(COLUMNS));
        r_s1_row_ok <= (w_row_ext < 32'(ROWS));
        r_s1_col    <= w_col_ext[CW-1:0];
        r_s1_row    <= w_row_ext[RW-1:0];
        r_s1_val    <= i_req.entry_value;
        r_s1_diff   <= w_diff;
    end

    // Scaling by the inverse step.
    logic          r_s2_vld;
    logic          r_s2_load;
    logic          r_s2_col_ok;
    logic          r_s2_row_ok;
    logic [CW-1:0] r_s2_col;
    logic [RW-1:0] r_s2_row;
    logic [31:0]   r_s2_val;
    logic [63:0]   r_s2_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_load   <= r_s1_load;
        r_s2_col_ok <= r_s1_col_ok;
        r_s2_row_ok <= r_s1_row_ok;
        r_s2_col    <= r_s1_col;
        r_s2_row    <= r_s1_row;
        r_s2_val    <= r_s1_val;
        r_s2_t      <= 64'(r_s1_diff) * 64'(r_inv_step);
    end

    // Table access: loads write and queries read in this same stage, so order is kept.
    logic [RW-1:0] r_lnr [NCOL];
    logic [NCOL-1:0] r_hnz;

    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [RW-1:0]   w_lnr_c;
    logic            w_hnz_c;
    logic [KW-1:0]   w_k;
    logic [15:0]     w_chi;
    logic [KW-1:0]   w_k_tap  [NTAP];
    logic [NTAP-1:0] w_tap_ok;
    logic [AW-1:0]   w_raddr  [NTAP];
    logic [31:0]     w_rdata  [NTAP];

    assign w_we    = r_s2_vld && r_s2_load && r_s2_col_ok && r_s2_row_ok;
    assign w_waddr = {r_s2_row, r_s2_col};

    always_comb begin
        w_lnr_c = r_lnr[r_s2_col];
        w_hnz_c = r_hnz[r_s2_col];
        if (r_s2_t[63:32] > 32'(w_lnr_c)) begin
            w_k   = KW'(w_lnr_c) + KW'(1);
            w_chi = '0;
        end else begin
            w_k   = r_s2_t[32 +: KW];
            w_chi = r_s2_t[31:16];
        end
        for (int i = 0; i < NTAP; i++) begin
            w_k_tap[i]  = w_k + KW'(i);
            w_tap_ok[i] = w_hnz_c && (w_k_tap[i] <= KW'(w_lnr_c));
            w_raddr[i]  = {w_k_tap[i][RW-1:0], r_s2_col};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NCOL; c++) begin
                r_lnr[c] <= '0;
            end
            r_hnz <= '0;
        end else if (w_we && (r_s2_val != 32'd0)) begin
            if (!r_hnz[r_s2_col] || (r_s2_row > r_lnr[r_s2_col])) begin
                r_lnr[r_s2_col] <= r_s2_row;
            end
            r_hnz[r_s2_col] <= 1'b1;
        end
    end

    genvar gi;
    for (gi = 0; gi < NTAP; gi++) begin : g_ram
        qti_ram #(
            .WIDTH (32),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_waddr),
            .i_wdata (r_s2_val),
            .i_raddr (w_raddr[gi]),
            .o_rdata (w_rdata[gi])
        );
    end

    logic            r_s3_vld;
    logic            r_s3_col_ok;
    logic [15:0]     r_s3_chi;
    logic [NTAP-1:0] r_s3_tap_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld && !r_s2_load;
        end
        r_s3_col_ok <= r_s2_col_ok;
        r_s3_chi    <= w_chi;
        r_s3_tap_ok <= w_tap_ok;
    end

    // Differences and the curvature weight.
    logic signed [31:0] w_p [NTAP];
    logic signed [32:0] w_dv;
    logic signed [33:0] w_d2v;
    logic        [32:0] w_m;

    always_comb begin
        for (int i = 0; i < NTAP; i++) begin
            w_p[i] = r_s3_tap_ok[i] ? $signed(w_rdata[i]) : 32'sd0;
        end
        w_dv  = 33'(w_p[1]) - 33'(w_p[0]);
        w_d2v = 34'(w_p[2]) - (34'(w_p[1]) <<< 1) + 34'(w_p[0]);
        w_m   = 33'(r_s3_chi) * 33'(qti_pkg::CHI_ONE - 17'(r_s3_chi));
    end

    logic               r_s4_vld;
    logic               r_s4_col_ok;
    logic [15:0]        r_s4_chi;
    logic signed [31:0] r_s4_p0;
    logic signed [32:0] r_s4_dv;
    logic signed [33:0] r_s4_d2v;
    logic        [30:0] r_s4_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
        r_s4_col_ok <= r_s3_col_ok;
        r_s4_chi    <= r_s3_chi;
        r_s4_p0     <= w_p[0];
        r_s4_dv     <= w_dv;
        r_s4_d2v    <= w_d2v;
        r_s4_m      <= w_m[30:0];
    end

    // Products.
    logic signed [16:0] w_chi_c;
    logic signed [49:0] w_prod_a;
    logic signed [64:0] w_prod_b;
    logic signed [50:0] w_prod_c;

    assign w_chi_c  = $signed({1'b0, r_s4_chi}) - $signed({1'b0, qti_pkg::CHI_HALF});
    assign w_prod_a = 50'($signed({1'b0, r_s4_chi})) * 50'(r_s4_dv);
    assign w_prod_b = 65'($signed({1'b0, r_s4_m})) * 65'(r_s4_d2v);
    assign w_prod_c = 51'(w_chi_c) * 51'(r_s4_d2v);

    logic               r_s5_vld;
    logic               r_s5_col_ok;
    logic signed [31:0] r_s5_p0;
    logic signed [32:0] r_s5_dv;
    logic signed [49:0] r_s5_prod_a;
    logic signed [64:0] r_s5_prod_b;
    logic signed [50:0] r_s5_prod_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else begin
            r_s5_vld <= r_s4_vld;
        end
        r_s5_col_ok <= r_s4_col_ok;
        r_s5_p0     <= r_s4_p0;
        r_s5_dv     <= r_s4_dv;
        r_s5_prod_a <= w_prod_a;
        r_s5_prod_b <= w_prod_b;
        r_s5_prod_c <= w_prod_c;
    end

    // Sums, floors and the value's saturation.
    logic signed [51:0] w_acc;
    logic signed [51:0] w_inner;

    assign w_acc   = (52'(r_s5_p0) <<< 16) + 52'(r_s5_prod_a) - 52'(r_s5_prod_b >>> 17);
    assign w_inner = (52'(r_s5_dv) <<< 16) + 52'(r_s5_prod_c);

    logic               r_s6_vld;
    logic               r_s6_col_ok;
    logic signed [31:0] r_s6_pot;
    logic signed [35:0] r_s6_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else begin
            r_s6_vld <= r_s5_vld;
        end
        r_s6_col_ok <= r_s5_col_ok;
        r_s6_pot    <= sat_q(54'($signed(w_acc[51:16])));
        r_s6_g      <= w_inner[51:16];
    end

    // Gradient scaling in two partial products.
    logic signed [52:0] w_gh;
    logic signed [52:0] w_gl;

    assign w_gh = 53'(r_s6_g) * 53'($signed({1'b0, r_inv_step[31:16]}));
    assign w_gl = 53'(r_s6_g) * 53'($signed({1'b0, r_inv_step[15:0]}));

    logic               r_s7_vld;
    logic               r_s7_col_ok;
    logic signed [31:0] r_s7_pot;
    logic signed [52:0] r_s7_gh;
    logic signed [52:0] r_s7_gl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_vld <= 1'b0;
        end else begin
            r_s7_vld <= r_s6_vld;
        end
        r_s7_col_ok <= r_s6_col_ok;
        r_s7_pot    <= r_s6_pot;
        r_s7_gh     <= w_gh;
        r_s7_gl     <= w_gl;
    end

    logic signed [69:0] w_gsum;

    assign w_gsum = (70'(r_s7_gh) <<< 16) + 70'(r_s7_gl);

    logic          r_res_valid;
    qti_pkg::t_res r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= r_s7_vld;
        end
        if (r_s7_col_ok) begin
            r_res.pot_value <= r_s7_pot;
            r_res.gradient  <= sat_q(54'($signed(w_gsum[69:16])));
        end else begin
            r_res <= '0;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ===== hdl/qti_checker.sv =====
// Port-level checker of the quadratic table interpolator, bound to its top level.
// Depends on qti_pkg and quadratic_table_interpolator_top_defines.svh.
`default_nettype none

`include "quadratic_table_interpolator_top_defines.svh"

module qti_checker #(
    parameter int COLUMNS = 16
) (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire qti_pkg::t_req i_req,
    input wire logic          o_res_valid,
    input wire qti_pkg::t_res o_res
);

    localparam int LATENCY = 8;

    logic w_query;
    logic w_bad_query;

    assign w_query     = start && !busy && (i_req.req_type == qti_pkg::REQ_QUERY);
    assign w_bad_query = w_query && (32'(i_req.column) >= 32'(COLUMNS));

    `QTI_ASSERT(a_query_gives_result, w_query |-> ##LATENCY o_res_valid, "query item lost")
    `QTI_ASSERT(a_result_from_query, o_res_valid |-> $past(w_query, LATENCY), "result without query item")
    `QTI_ASSERT(a_bad_column_zero, $past(w_bad_query, LATENCY) |-> (o_res == '0), "bad column result not zero")
    `QTI_ASSERT_ALWAYS(a_reset_flushes, !i_rst_n |=> !o_res_valid, "result strobe after reset")

endmodule

bind quadratic_table_interpolator_top qti_checker #(.COLUMNS(COLUMNS)) u_qti_checker (.*);

`default_nettype wire

// ===== dv/quadratic_table_interpolator_top_test.sv =====
// Self-checking testbench for quadratic_table_interpolator_top: loads table entries, runs
// position queries under several register settings and checks each interpolated result.
// Depends on qti_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module quadratic_table_interpolator_top_test;

    localparam int ROWS    = 1024;
    localparam int COLUMNS = 16;

    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start   = 1'b0;
    logic                        busy;
    qti_pkg::t_req               i_req   = '0;
    logic                        o_res_valid;
    qti_pkg::t_res               o_res;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [qti_pkg::PADDR_W-1:0] paddr   = '0;
    logic [31:0]                 pwdata  = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // Shadow of the block's table, row records and registers.
    logic [31:0]         table_mem [ROWS*COLUMNS];
    logic [9:0]          top_row [COLUMNS];
    logic                col_live [COLUMNS];
    logic [31:0]         cfg_table_start = qti_pkg::TABLE_START_RESET;
    logic [31:0]         cfg_inv_step    = qti_pkg::INVERSE_STEP_RESET;

    // Stimulus bookkeeping: rows below prefix_len are all loaded, so no query reads a hole.
    int                  prefix_len [COLUMNS];
    bit                  row_loaded [ROWS*COLUMNS];

    qti_pkg::t_req       req_backlog [$];
    qti_pkg::t_res       interp_due [$];
    qti_pkg::t_res       oldest;
    int                  errors   = 0;
    int                  idle_pct = 27;

    quadratic_table_interpolator_top #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [31:0] clip32(logic signed [95:0] x);
        if (x > 96'sd2147483647) return 32'h7FFF_FFFF;
        if (x < -96'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    function automatic logic signed [95:0] table_read(int col, logic [63:0] row);
        if (!col_live[col] || row > {54'd0, top_row[col]} || row >= ROWS) return '0;
        return $signed(table_mem[int'(row) * COLUMNS + col]);
    endfunction

    function automatic qti_pkg::t_res interpolate(qti_pkg::t_req r);
        int                 c;
        logic [31:0]        offset;
        logic [63:0]        scaled;
        logic [63:0]        k;
        logic [15:0]        chi;
        logic signed [95:0] p0, p1, p2, dv, d2v, chi_w, wt, acc, inner, g;
        qti_pkg::t_res      res;
        c = int'(r.column);
        if (c >= COLUMNS) return '0;
        offset = (r.query_position >= cfg_table_start) ? r.query_position - cfg_table_start : '0;
        scaled = {32'd0, offset} * {32'd0, cfg_inv_step};
        k      = scaled >> 32;
        chi    = scaled[31:16];
        if (k > {54'd0, top_row[c]}) begin
            k   = {54'd0, top_row[c]} + 64'd1;
            chi = '0;
        end
        p0    = table_read(c, k);
        p1    = table_read(c, k + 64'd1);
        p2    = table_read(c, k + 64'd2);
        dv    = p1 - p0;
        d2v   = p2 - 2 * p1 + p0;
        chi_w = {80'd0, chi};
        wt    = chi_w * (65536 - chi_w);
        acc   = p0 * 65536 + chi_w * dv - ((wt * d2v) >>> 17);
        inner = dv * 65536 + (chi_w - 32768) * d2v;
        g     = inner >>> 16;
        res.pot_value = clip32(acc >>> 16);
        res.gradient  = clip32((g * $signed({64'd0, cfg_inv_step})) >>> 16);
        return res;
    endfunction

    function automatic void absorb_item(qti_pkg::t_req r);
        int c;
        int row;
        c   = int'(r.column);
        row = int'(r.row_index);
        if (r.req_type == qti_pkg::REQ_QUERY) begin
            interp_due.push_back(interpolate(r));
        end else if (c < COLUMNS && row < ROWS) begin
            table_mem[row * COLUMNS + c] = r.entry_value;
            if (r.entry_value != 0) begin
                if (!col_live[c] || r.row_index > top_row[c]) top_row[c] = r.row_index;
                col_live[c] = 1'b1;
            end
        end
    endfunction

    // Driver: the head of the backlog is the item on the ports until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                absorb_item(i_req);
                req_backlog.delete(0);
            end
            if (!(start && busy)) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    start <= 1'b1;
                    i_req <= req_backlog[0];
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: results cannot be held off, so every strobe is taken as it comes.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (interp_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got pot %h grad %h",
                         $time, o_res.pot_value, o_res.gradient);
                errors++;
            end else begin
                oldest = interp_due.pop_front();
                if (o_res.pot_value !== oldest.pot_value) begin
                    $display("%0t: pot_value expected %h, got %h",
                             $time, oldest.pot_value, o_res.pot_value);
                    errors++;
                end
                if (o_res.gradient !== oldest.gradient) begin
                    $display("%0t: gradient expected %h, got %h",
                             $time, oldest.gradient, o_res.gradient);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(7))
            0, 1: return $urandom;
            2:    return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3:    return 32'($urandom_range(99)) == 0 ? 32'h0 : 32'hFFFF_FFFF;
            default: return 32'($urandom_range(32'h0040_0000)) - 32'h0020_0000;
        endcase
    endfunction

    task automatic push_load(int row, int col, logic [31:0] val);
        qti_pkg::t_req r;
        r.req_type       = qti_pkg::REQ_LOAD;
        r.row_index      = row[9:0];
        r.column         = col[3:0];
        r.entry_value    = val;
        r.query_position = $urandom;
        req_backlog.push_back(r);
        row_loaded[row * COLUMNS + col] = 1'b1;
        while (prefix_len[col] < ROWS && row_loaded[prefix_len[col] * COLUMNS + col])
            prefix_len[col]++;
    endtask

    task automatic push_query(int col, logic [31:0] pos);
        qti_pkg::t_req r;
        r.req_type       = qti_pkg::REQ_QUERY;
        r.row_index      = 10'($urandom);
        r.column         = col[3:0];
        r.entry_value    = $urandom;
        r.query_position = pos;
        req_backlog.push_back(r);
    endtask

    // A position that lands near a loaded row of the column under the current registers.
    function automatic logic [31:0] aim_position(int col);
        logic [63:0] num;
        logic [63:0] sum;
        num = {32'($urandom_range(prefix_len[col] + 2)), 32'($urandom)};
        if (cfg_inv_step == 0) return $urandom;
        sum = {32'd0, cfg_table_start} + num / {32'd0, cfg_inv_step};
        return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    task automatic drain();
        int spins;
        spins = 0;
        while ((req_backlog.size() != 0 || interp_due.size() != 0) && spins < 20000) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (12) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [qti_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
        logic [31:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == qti_pkg::REG_TABLE_START) cfg_table_start = val;
        else cfg_inv_step = val;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got      = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== val) begin
            $display("%0t: register %0d read expected %h, got %h", $time, idx, val, got);
            errors++;
        end
    endtask

    task automatic run_phase(logic [31:0] ts, logic [31:0] inv, int n_items, int idle);
        int made;
        int c;
        int len;
        int kind;
        drain();
        reg_write(qti_pkg::REG_TABLE_START, ts);
        reg_write(qti_pkg::REG_INVERSE_STEP, inv);
        idle_pct = idle;
        made = 0;
        while (made < n_items) begin
            c    = $urandom_range(COLUMNS - 1);
            kind = $urandom_range(99);
            if (kind < 55) begin
                len = $urandom_range(12, 1);
                repeat (len) begin
                    if (prefix_len[c] < ROWS) begin
                        push_load(prefix_len[c], c, rand_entry());
                        made++;
                    end
                end
                len = $urandom_range(6, 2);
                repeat (len) begin
                    push_query(c, aim_position(c));
                    made++;
                end
            end else if (kind < 80) begin
                push_query(c, $urandom);
                made++;
            end else if (kind < 90) begin
                push_load($urandom_range(ROWS - 1), c, 32'h0);
                made++;
            end else begin
                push_load($urandom_range(prefix_len[c] < ROWS ? prefix_len[c] : ROWS - 1),
                          c, rand_entry());
                made++;
            end
        end
    endtask

    initial begin
        foreach (top_row[i]) begin
            top_row[i]    = '0;
            col_live[i]   = 1'b0;
            prefix_len[i] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_query(0, 32'h0);
        push_load(0, 0, 32'h7FFF_FFFF);
        push_load(1, 0, 32'h8000_0000);
        push_load(2, 0, 32'h7FFF_FFFF);
        push_load(3, 0, 32'h0001_0000);
        push_load(4, 0, 32'h0);
        push_load(3, 0, 32'h0);
        push_load(0, 15, 32'hFFFF_FFFF);
        push_load(1023, 15, 32'h0);
        push_query(0, 32'h0000_0000);
        push_query(0, 32'h0000_8000);
        push_query(0, 32'h0001_FFFF);
        push_query(0, 32'h0002_C000);
        push_query(0, 32'h0003_0000);
        push_query(0, 32'h0004_0000);
        push_query(0, 32'hFFFF_FFFF);
        push_query(15, 32'h0);
        push_query(15, 32'hFFFF_FFFF);
        push_query(1, 32'h0001_2345);

        run_phase(32'h0, 32'h0001_0000, 200, 0);
        run_phase($urandom_range(32'h000F_FFFF), $urandom_range(32'h0004_0000, 32'h0000_8000),
                  200, 27);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 120, 27);
        run_phase(32'h0, 32'h0, 120, 27);
        run_phase($urandom, $urandom, 150, 27);
        run_phase(32'h0001_0000, 32'h0002_0000, 200, 27);
        run_phase(32'h0, 32'h0000_4000, 120, 27);

        drain();
        if (interp_due.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, interp_due.size());
            errors++;
        end
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
